@@ hdl/ctu_pkg.sv @@
package ctu_pkg;

  // field widths of the transaction payloads
  localparam int unsigned KIND_W = 4;
  localparam int unsigned ID_FIELD_W = 32;
  localparam int unsigned CAP_FIELD_W = 64;

  // capability bits that gate privileged requests
  localparam int unsigned CAP_BIT_SETGID = 6;
  localparam int unsigned CAP_BIT_SETUID = 7;
  localparam int unsigned CAP_BIT_SETPCAP = 8;

  // response status codes
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_DENIED = 1'b1;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SETUID    = 4'd0,
    KIND_SETGID    = 4'd1,
    KIND_SETREUID  = 4'd2,
    KIND_SETREGID  = 4'd3,
    KIND_SETRESUID = 4'd4,
    KIND_SETRESGID = 4'd5,
    KIND_SETFSUID  = 4'd6,
    KIND_SETFSGID  = 4'd7,
    KIND_CAPSET    = 4'd8
  } kind_e;

  // request payload
  typedef struct packed {
    logic [KIND_W-1:0]             kind;
    logic signed [ID_FIELD_W-1:0]  id_real;
    logic signed [ID_FIELD_W-1:0]  id_effective;
    logic signed [ID_FIELD_W-1:0]  id_saved;
    logic [CAP_FIELD_W-1:0]        new_effective_caps;
    logic [CAP_FIELD_W-1:0]        new_permitted_caps;
    logic [CAP_FIELD_W-1:0]        new_inheritable_caps;
  } req_t;

  // response payload
  typedef struct packed {
    logic                          status;
    logic signed [ID_FIELD_W-1:0]  previous_fs_id;
  } rsp_t;

endpackage

@@ hdl/ctu_if.sv @@
// request channel
interface ctu_req_if;
  logic          valid;
  logic          ready;
  ctu_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// response channel
interface ctu_rsp_if;
  logic          valid;
  logic          ready;
  ctu_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// bounding set write channel
interface ctu_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ctu_pkg::CAP_FIELD_W-1:0]     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/ctu_core.sv @@
module ctu_core #(
  parameter int unsigned ID_WIDTH  = 32,
  parameter int unsigned CAP_WIDTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  ctu_pkg::req_t                    req_i,
  input  logic [ctu_pkg::CAP_FIELD_W-1:0]  bounding_i,
  output ctu_pkg::rsp_t                    rsp_o
);

  typedef struct packed {
    logic [ID_WIDTH-1:0] r;
    logic [ID_WIDTH-1:0] e;
    logic [ID_WIDTH-1:0] s;
    logic [ID_WIDTH-1:0] f;
  } id_set_t;

  localparam logic [ID_WIDTH-1:0] ID_ZERO = '0;

  id_set_t uid_q, uid_d, gid_q, gid_d;
  logic [CAP_WIDTH-1:0] cap_e_q, cap_e_d, cap_p_q, cap_p_d, cap_i_q, cap_i_d;

  id_set_t cur, nxt;
  logic [ID_WIDTH-1:0] a, b, c;
  logic [CAP_WIDTH-1:0] ne, np, ni, allowed;
  logic is_uid, priv, status, commit;
  logic keep_a, keep_b, keep_c, held_a, held_b, held_c, may_a, may_b, may_c;
  logic signed [ID_WIDTH-1:0] fs_old;
  logic signed [ctu_pkg::ID_FIELD_W-1:0] prev;
  logic had_root, has_root;

  // operand slicing and privilege
  assign a = req_i.id_real[ID_WIDTH-1:0];
  assign b = req_i.id_effective[ID_WIDTH-1:0];
  assign c = req_i.id_saved[ID_WIDTH-1:0];
  assign ne = req_i.new_effective_caps[CAP_WIDTH-1:0];
  assign np = req_i.new_permitted_caps[CAP_WIDTH-1:0];
  assign ni = req_i.new_inheritable_caps[CAP_WIDTH-1:0];
  assign is_uid = ~req_i.kind[0];
  assign priv = is_uid ? cap_e_q[ctu_pkg::CAP_BIT_SETUID] : cap_e_q[ctu_pkg::CAP_BIT_SETGID];
  assign cur = is_uid ? uid_q : gid_q;

  // id checks against the current class
  assign keep_a = &a;
  assign keep_b = &b;
  assign keep_c = &c;
  assign held_a = (a == cur.r) || (a == cur.e) || (a == cur.s);
  assign held_b = (b == cur.r) || (b == cur.e) || (b == cur.s);
  assign held_c = (c == cur.r) || (c == cur.e) || (c == cur.s);
  assign may_a = priv || keep_a || held_a;
  assign may_b = priv || keep_b || held_b;
  assign may_c = priv || keep_c || held_c;
  assign fs_old = cur.f;

  // allowed inheritable set for capset
  always_comb begin
    allowed = cap_i_q | cap_p_q;
    if (cap_e_q[ctu_pkg::CAP_BIT_SETPCAP]) begin
      allowed = allowed | bounding_i[CAP_WIDTH-1:0];
    end
  end

  // request decode and new id set
  always_comb begin
    nxt = cur;
    status = ctu_pkg::STATUS_OK;
    prev = '0;
    case (req_i.kind) inside
      ctu_pkg::KIND_SETUID, ctu_pkg::KIND_SETGID: begin
        if (!keep_a) begin
          if (priv) begin
            nxt.r = a;
            nxt.e = a;
            nxt.s = a;
            nxt.f = a;
          end else if (held_a) begin
            nxt.e = a;
            nxt.f = a;
          end else begin
            status = ctu_pkg::STATUS_DENIED;
          end
        end
      end
      ctu_pkg::KIND_SETREUID, ctu_pkg::KIND_SETREGID: begin
        if (!(may_a && may_b)) begin
          status = ctu_pkg::STATUS_DENIED;
        end else begin
          if (!keep_a) nxt.r = a;
          if (!keep_b) begin
            nxt.e = b;
            nxt.f = b;
          end
          if (!keep_a || !keep_b) nxt.s = keep_b ? cur.e : b;
        end
      end
      ctu_pkg::KIND_SETRESUID, ctu_pkg::KIND_SETRESGID: begin
        if (!(may_a && may_b && may_c)) begin
          status = ctu_pkg::STATUS_DENIED;
        end else begin
          if (!keep_a) nxt.r = a;
          if (!keep_b) begin
            nxt.e = b;
            nxt.f = b;
          end
          if (!keep_c) nxt.s = c;
        end
      end
      ctu_pkg::KIND_SETFSUID, ctu_pkg::KIND_SETFSGID: begin
        prev = ctu_pkg::ID_FIELD_W'(fs_old);
        if (!a[ID_WIDTH-1] && (priv || held_a)) begin
          nxt.f = a;
        end else begin
          status = ctu_pkg::STATUS_DENIED;
        end
      end
      ctu_pkg::KIND_CAPSET: begin
        if (((ne & ~np) != '0) || ((np & ~cap_p_q) != '0) || ((ni & ~allowed) != '0)) begin
          status = ctu_pkg::STATUS_DENIED;
        end
      end
      default: begin
        status = ctu_pkg::STATUS_DENIED;
      end
    endcase
  end

  assign commit = fire_i && (status == ctu_pkg::STATUS_OK);

  // root-loss rules over the old and new uid sets
  assign had_root = (uid_q.r == ID_ZERO) || (uid_q.e == ID_ZERO) || (uid_q.s == ID_ZERO);
  assign has_root = (nxt.r == ID_ZERO) || (nxt.e == ID_ZERO) || (nxt.s == ID_ZERO);

  // next state
  always_comb begin
    uid_d = uid_q;
    gid_d = gid_q;
    cap_e_d = cap_e_q;
    cap_p_d = cap_p_q;
    cap_i_d = cap_i_q;
    if (commit) begin
      if (req_i.kind == ctu_pkg::KIND_CAPSET) begin
        cap_e_d = ne;
        cap_p_d = np;
        cap_i_d = ni;
      end else if (is_uid) begin
        uid_d = nxt;
        if (had_root && !has_root) begin
          cap_e_d = '0;
          cap_p_d = '0;
        end else if ((uid_q.e == ID_ZERO) && (nxt.e != ID_ZERO)) begin
          cap_e_d = '0;
        end else if ((uid_q.e != ID_ZERO) && (nxt.e == ID_ZERO)) begin
          cap_e_d = cap_p_q;
        end
      end else begin
        gid_d = nxt;
      end
    end
  end

  // credential registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uid_q <= '0;
      gid_q <= '0;
      cap_e_q <= '1;
      cap_p_q <= '1;
      cap_i_q <= '0;
    end else begin
      uid_q <= uid_d;
      gid_q <= gid_d;
      cap_e_q <= cap_e_d;
      cap_p_q <= cap_p_d;
      cap_i_q <= cap_i_d;
    end
  end

  assign rsp_o.status = status;
  assign rsp_o.previous_fs_id = prev;

  // a refused request leaves every credential as it was
  a_denied_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (status == ctu_pkg::STATUS_DENIED)
    |=> $stable(uid_q) && $stable(gid_q) && $stable(cap_e_q) && $stable(cap_p_q)
        && $stable(cap_i_q))
    else $error("refused request changed credentials");

  // fs requests never touch the capability sets
  a_fs_keeps_caps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && ((req_i.kind == ctu_pkg::KIND_SETFSUID) || (req_i.kind == ctu_pkg::KIND_SETFSGID))
    |=> $stable(cap_e_q) && $stable(cap_p_q) && $stable(cap_i_q))
    else $error("fs request changed capability sets");

  // an accepted capset keeps effective within permitted
  a_capset_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (req_i.kind == ctu_pkg::KIND_CAPSET) |=> ((cap_e_q & ~cap_p_q) == '0))
    else $error("capset left effective outside permitted");

endmodule

@@ hdl/credential_transition_unit.sv @@
// credential_transition_unit
// a request passes through the input register and then the result register before its response is valid
// one request per cycle while response backpressure does not stall the output register
// response backpressure stalls the input register; a new request still enters while it is empty
// reset: ids cleared, effective and permitted sets all ones, inheritable clear, bounding all ones
module credential_transition_unit #(
  parameter int unsigned ID_WIDTH  = 32,
  parameter int unsigned CAP_WIDTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ctu_req_if.sink        req_i,
  ctu_rsp_if.source      rsp_o,
  ctu_cfg_if.sink        cfg_i
);

  ctu_pkg::req_t req_q, req_d;
  ctu_pkg::rsp_t rsp_q, rsp_d, core_rsp;
  logic in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  logic advance, fire, in_take;
  logic [ctu_pkg::CAP_FIELD_W-1:0] bounding_q, bounding_d;

  // handshake control
  assign advance = !out_valid_q || rsp_o.ready;
  assign fire = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;
  assign in_take = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // next values of the stage registers
  always_comb begin
    req_d = in_take ? req_i.payload : req_q;
    in_valid_d = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_q);
    rsp_d = fire ? core_rsp : rsp_q;
    out_valid_d = fire ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);
    bounding_d = (cfg_i.valid && cfg_i.ready) ? cfg_i.data : bounding_q;
  end

  // control and bounding registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      bounding_q <= '1;
    end else begin
      in_valid_q <= in_valid_d;
      out_valid_q <= out_valid_d;
      bounding_q <= bounding_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  // credential state and decision logic
  ctu_core #(
    .ID_WIDTH  (ID_WIDTH),
    .CAP_WIDTH (CAP_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .req_i      (req_q),
    .bounding_i (bounding_q),
    .rsp_o      (core_rsp)
  );

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.payload = rsp_q;

  // every processed request shows up as a response next cycle
  a_fire_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed request produced no response");

  // a stalled input register keeps its request
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(req_q))
    else $error("stalled request lost");

  // both stages full and output stalled blocks new requests
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken while pipeline full");

endmodule

@@ tb/sv/tb.sv @@
module tb;

  typedef logic [ctu_pkg::ID_FIELD_W-1:0] id_t;
  typedef logic [ctu_pkg::CAP_FIELD_W-1:0] cap_t;

  // credentials of the modeled process
  typedef struct {
    id_t  ruid, euid, suid, fsuid;
    id_t  rgid, egid, sgid, fsgid;
    cap_t eff, perm, inh;
  } cred_t;

  // response ready patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_HOLD} rx_mode_e;

  localparam id_t ID_KEEP = '1;
  localparam logic [ctu_pkg::KIND_W-1:0] KIND_UNUSED_FIRST = 4'd9;
  localparam logic [ctu_pkg::KIND_W-1:0] KIND_UNUSED_LAST = 4'd15;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ctu_req_if req_bus ();
  ctu_rsp_if rsp_bus ();
  ctu_cfg_if cfg_bus ();

  credential_transition_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  cred_t         creds;
  cap_t          bound_mask;
  ctu_pkg::rsp_t expected_rsp[$];
  int            mismatches = 0;
  int            burst_left = 0;
  rx_mode_e      stall_mode = RX_OPEN;
  int            stall_left = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t %s: got %h want %h", $time, what, got, want);
  endtask

  function automatic bit holds_id(id_t v, id_t r, id_t e, id_t s);
    return v == r || v == e || v == s;
  endfunction

  function automatic bit may_take(bit priv, id_t v, id_t r, id_t e, id_t s);
    return priv || v == ID_KEEP || holds_id(v, r, e, s);
  endfunction

  // root-loss rules after a uid change
  function automatic void recompute_caps(ref cred_t c, input id_t oldr, input id_t olde,
                                         input id_t olds);
    bit had_root, has_root;
    had_root = oldr == '0 || olde == '0 || olds == '0;
    has_root = c.ruid == '0 || c.euid == '0 || c.suid == '0;
    if (had_root && !has_root) begin
      c.eff = '0;
      c.perm = '0;
    end else if (olde == '0 && c.euid != '0) begin
      c.eff = '0;
    end else if (olde != '0 && c.euid == '0) begin
      c.eff = c.perm;
    end
  endfunction

  // applies one request to the credentials and returns its response
  function automatic ctu_pkg::rsp_t apply_request(ref cred_t c, input ctu_pkg::req_t r);
    ctu_pkg::rsp_t rsp;
    bit   for_uid, priv;
    id_t  a, b, s3, pr, pe, ps, pf, oldr, olde, olds;
    cap_t allowed;
    rsp.status = ctu_pkg::STATUS_OK;
    rsp.previous_fs_id = '0;
    a = r.id_real;
    b = r.id_effective;
    s3 = r.id_saved;
    for_uid = !r.kind[0];
    priv = c.eff[for_uid ? ctu_pkg::CAP_BIT_SETUID : ctu_pkg::CAP_BIT_SETGID];
    pr = for_uid ? c.ruid : c.rgid;
    pe = for_uid ? c.euid : c.egid;
    ps = for_uid ? c.suid : c.sgid;
    pf = for_uid ? c.fsuid : c.fsgid;
    oldr = c.ruid;
    olde = c.euid;
    olds = c.suid;
    case (r.kind)
      ctu_pkg::KIND_SETUID, ctu_pkg::KIND_SETGID: begin
        if (a != ID_KEEP) begin
          if (priv) begin
            pr = a;
            pe = a;
            ps = a;
            pf = a;
          end else if (holds_id(a, pr, pe, ps)) begin
            pe = a;
            pf = a;
          end else begin
            rsp.status = ctu_pkg::STATUS_DENIED;
          end
        end
      end
      ctu_pkg::KIND_SETREUID, ctu_pkg::KIND_SETREGID: begin
        if (!may_take(priv, a, pr, pe, ps) || !may_take(priv, b, pr, pe, ps)) begin
          rsp.status = ctu_pkg::STATUS_DENIED;
        end else begin
          if (a != ID_KEEP) pr = a;
          if (b != ID_KEEP) begin
            pe = b;
            pf = b;
          end
          if (a != ID_KEEP || b != ID_KEEP) ps = pe;
        end
      end
      ctu_pkg::KIND_SETRESUID, ctu_pkg::KIND_SETRESGID: begin
        if (!may_take(priv, a, pr, pe, ps) || !may_take(priv, b, pr, pe, ps) ||
            !may_take(priv, s3, pr, pe, ps)) begin
          rsp.status = ctu_pkg::STATUS_DENIED;
        end else begin
          if (a != ID_KEEP) pr = a;
          if (b != ID_KEEP) begin
            pe = b;
            pf = b;
          end
          if (s3 != ID_KEEP) ps = s3;
        end
      end
      ctu_pkg::KIND_SETFSUID, ctu_pkg::KIND_SETFSGID: begin
        rsp.previous_fs_id = pf;
        if (!a[ctu_pkg::ID_FIELD_W-1] && (priv || holds_id(a, pr, pe, ps))) begin
          pf = a;
        end else begin
          rsp.status = ctu_pkg::STATUS_DENIED;
        end
      end
      ctu_pkg::KIND_CAPSET: begin
        allowed = c.inh | c.perm;
        if (c.eff[ctu_pkg::CAP_BIT_SETPCAP]) allowed |= bound_mask;
        if ((r.new_effective_caps & ~r.new_permitted_caps) != '0 ||
            (r.new_permitted_caps & ~c.perm) != '0 ||
            (r.new_inheritable_caps & ~allowed) != '0) begin
          rsp.status = ctu_pkg::STATUS_DENIED;
        end else begin
          c.eff = r.new_effective_caps;
          c.perm = r.new_permitted_caps;
          c.inh = r.new_inheritable_caps;
        end
      end
      default: begin
        rsp.status = ctu_pkg::STATUS_DENIED;
      end
    endcase
    // commit id changes of an accepted id request
    if (r.kind <= ctu_pkg::KIND_SETFSGID && rsp.status == ctu_pkg::STATUS_OK) begin
      if (for_uid) begin
        c.ruid = pr;
        c.euid = pe;
        c.suid = ps;
        c.fsuid = pf;
      end else begin
        c.rgid = pr;
        c.egid = pe;
        c.sgid = ps;
        c.fsgid = pf;
      end
      if (for_uid && r.kind <= ctu_pkg::KIND_SETRESUID) recompute_caps(c, oldr, olde, olds);
    end
    return rsp;
  endfunction

  function automatic ctu_pkg::req_t make_request(logic [ctu_pkg::KIND_W-1:0] kind, id_t a,
                                                 id_t b, id_t s, cap_t ne, cap_t np,
                                                 cap_t ni);
    ctu_pkg::req_t r;
    r.kind = kind;
    r.id_real = a;
    r.id_effective = b;
    r.id_saved = s;
    r.new_effective_caps = ne;
    r.new_permitted_caps = np;
    r.new_inheritable_caps = ni;
    return r;
  endfunction

  // id candidates biased toward held, root and keep values
  function automatic id_t pick_id(bit for_uid);
    id_t r, e, s, f;
    r = for_uid ? creds.ruid : creds.rgid;
    e = for_uid ? creds.euid : creds.egid;
    s = for_uid ? creds.suid : creds.sgid;
    f = for_uid ? creds.fsuid : creds.fsgid;
    case ($urandom_range(0, 11))
      0, 1: return ID_KEEP;
      2: return '0;
      3: return r;
      4: return e;
      5: return s;
      6: return f;
      7, 8: return id_t'($urandom_range(0, 7));
      9: return id_t'($urandom_range(1000, 1003));
      10: return {1'b1, 31'($urandom)};
      default: return id_t'($urandom);
    endcase
  endfunction

  function automatic cap_t rand_caps();
    return {$urandom, $urandom};
  endfunction

  // random request; with keep_privilege it must not lose setuid, setgid or setpcap
  function automatic ctu_pkg::req_t random_request(bit keep_privilege);
    ctu_pkg::req_t cand;
    cred_t trial;
    int    pick;
    bit    for_uid;
    cap_t  allowed;
    for (int tries = 0; tries < 16; tries++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        cand.kind = 4'($urandom_range(ctu_pkg::KIND_SETUID, ctu_pkg::KIND_SETFSGID));
      end else if (pick < 95) begin
        cand.kind = ctu_pkg::KIND_CAPSET;
      end else begin
        cand.kind = 4'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
      end
      for_uid = !cand.kind[0];
      cand.id_real = pick_id(for_uid);
      cand.id_effective = pick_id(for_uid);
      cand.id_saved = pick_id(for_uid);
      allowed = creds.inh | creds.perm |
                (creds.eff[ctu_pkg::CAP_BIT_SETPCAP] ? bound_mask : '0);
      if ($urandom_range(0, 4) == 0) begin
        cand.new_permitted_caps = rand_caps();
        cand.new_effective_caps = rand_caps();
        cand.new_inheritable_caps = rand_caps();
      end else begin
        cand.new_permitted_caps = creds.perm & (rand_caps() | rand_caps());
        cand.new_effective_caps = cand.new_permitted_caps & rand_caps();
        cand.new_inheritable_caps = allowed & rand_caps();
      end
      if (!keep_privilege) return cand;
      trial = creds;
      void'(apply_request(trial, cand));
      if (trial.perm[ctu_pkg::CAP_BIT_SETUID] && trial.perm[ctu_pkg::CAP_BIT_SETGID] &&
          trial.perm[ctu_pkg::CAP_BIT_SETPCAP]) begin
        return cand;
      end
    end
    // fs requests never touch the capability sets
    cand.kind = ctu_pkg::KIND_SETFSGID;
    return cand;
  endfunction

  // sends one request in bursts with random gaps, predicts at acceptance
  task automatic send_request(input ctu_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    req_bus.valid <= 1'b1;
    req_bus.payload <= r;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    expected_rsp.push_back(apply_request(creds, r));
    @(negedge clk_i);
  endtask

  // drain all pending responses and let the pipeline empty
  task automatic settle();
    req_bus.valid <= 1'b0;
    burst_left = 0;
    while (expected_rsp.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_bounding(input cap_t value);
    settle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= value;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    bound_mask = value;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit keep_privilege);
    repeat (count) send_request(random_request(keep_privilege));
  endtask

  // keep value, fs ids at the sign boundary
  task automatic test_keep_and_fs();
    send_request(make_request(ctu_pkg::KIND_SETUID, ID_KEEP, '0, '0, '0, '0, '0));
    send_request(make_request(ctu_pkg::KIND_SETGID, ID_KEEP, '0, '0, '0, '0, '0));
    send_request(make_request(ctu_pkg::KIND_SETFSUID, 32'h7fff_ffff, '0, '0, '0, '0, '0));
    send_request(make_request(ctu_pkg::KIND_SETFSUID, 32'hffff_fffb, '0, '0, '0, '0, '0));
    send_request(make_request(ctu_pkg::KIND_SETFSGID, 32'h8000_0000, '0, '0, '0, '0, '0));
  endtask

  // gid kinds while privileged
  task automatic test_gid_kinds();
    send_request(make_request(ctu_pkg::KIND_SETGID, 32'd1000, '0, '0, '0, '0, '0));
    send_request(make_request(ctu_pkg::KIND_SETREGID, ID_KEEP, ID_KEEP, '0, '0, '0, '0));
    send_request(make_request(ctu_pkg::KIND_SETREGID, 32'd10, ID_KEEP, '0, '0, '0, '0));
    send_request(make_request(ctu_pkg::KIND_SETRESGID, 32'd5, 32'd6, 32'd7, '0, '0, '0));
    send_request(make_request(ctu_pkg::KIND_SETFSGID, 32'd6, '0, '0, '0, '0, '0));
  endtask

  // effective uid leaving and regaining root while root is kept
  task automatic test_root_transitions();
    send_request(make_request(ctu_pkg::KIND_SETRESUID, ID_KEEP, 32'd5, ID_KEEP, '0, '0, '0));
    send_request(make_request(ctu_pkg::KIND_SETRESUID, ID_KEEP, 32'd0, ID_KEEP, '0, '0, '0));
    send_request(make_request(ctu_pkg::KIND_SETREUID, 32'd0, 32'd100, '0, '0, '0, '0));
    send_request(make_request(ctu_pkg::KIND_SETUID, 32'd0, '0, '0, '0, '0, '0));
  endtask

  // capset subset rules and the bounding set widening
  task automatic test_capset_rules();
    send_request(make_request(ctu_pkg::KIND_CAPSET, '0, '0, '0, 64'h1ff, 64'h1ff, '0));
    send_request(make_request(ctu_pkg::KIND_CAPSET, '0, '0, '0, 64'h1ff, 64'h1ff,
                              64'h8000_0000_0000_0000));
    write_bounding('0);
    send_request(make_request(ctu_pkg::KIND_CAPSET, '0, '0, '0, 64'h1ff, 64'h1ff,
                              64'h4000_0000_0000_0000));
    send_request(make_request(ctu_pkg::KIND_CAPSET, '0, '0, '0, 64'h0ff, 64'h1ff,
                              64'h8000_0000_0000_0001));
    write_bounding('1);
    send_request(make_request(ctu_pkg::KIND_CAPSET, '0, '0, '0, 64'h0ff, 64'h1ff,
                              64'h4000_0000_0000_0000));
    send_request(make_request(ctu_pkg::KIND_CAPSET, '0, '0, '0, 64'h3ff, 64'h1ff, '0));
    send_request(make_request(ctu_pkg::KIND_CAPSET, '0, '0, '0, 64'h3ff, 64'h3ff, '0));
  endtask

  task automatic test_unknown_kind();
    send_request(make_request(KIND_UNUSED_FIRST, '1, '1, '1, '1, '1, '1));
    send_request(make_request(KIND_UNUSED_LAST, '0, '0, '0, '0, '0, '0));
  endtask

  // random traffic that keeps root and privilege, across bounding settings
  task automatic test_random_privileged();
    write_bounding(rand_caps());
    run_random(400, 1'b1);
    write_bounding('0);
    run_random(400, 1'b1);
    write_bounding(cap_t'(1) << $urandom_range(0, ctu_pkg::CAP_FIELD_W - 1));
    run_random(400, 1'b1);
    write_bounding('1);
    run_random(400, 1'b1);
  endtask

  // drop root for good, then unprivileged traffic
  task automatic test_random_unprivileged();
    send_request(make_request(ctu_pkg::KIND_CAPSET, '0, '0, '0, creds.perm, creds.perm,
                              creds.inh));
    send_request(make_request(ctu_pkg::KIND_SETRESUID, 32'd1000, 32'd1001, 32'd1002,
                              '0, '0, '0));
    run_random(400, 1'b0);
  endtask

  // response ready pattern
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_mode)
      RX_OPEN: rsp_bus.ready <= 1'b1;
      RX_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
      RX_MOSTLY: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      default: rsp_bus.ready <= (stall_left < 4);
    endcase
  end

  // response check against the oldest prediction
  always @(posedge clk_i) begin : check_responses
    ctu_pkg::rsp_t got, want;
    if (rst_ni && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      got = rsp_bus.payload;
      if (expected_rsp.size() == 0) begin
        report_mismatch("response with none pending", 64'(got), '0);
      end else begin
        want = expected_rsp.pop_front();
        if (got.status !== want.status) begin
          report_mismatch("status", 64'(got.status), 64'(want.status));
        end
        if (got.previous_fs_id !== want.previous_fs_id) begin
          report_mismatch("previous_fs_id", 64'(got.previous_fs_id),
                          64'(want.previous_fs_id));
        end
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("credential_transition_unit: mismatch");
    $finish;
  end

  initial begin
    int waited;
    req_bus.valid = 1'b0;
    req_bus.payload = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    rsp_bus.ready = 1'b0;
    creds.ruid = '0;
    creds.euid = '0;
    creds.suid = '0;
    creds.fsuid = '0;
    creds.rgid = '0;
    creds.egid = '0;
    creds.sgid = '0;
    creds.fsgid = '0;
    creds.eff = '1;
    creds.perm = '1;
    creds.inh = '0;
    bound_mask = '1;

    // reset
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_keep_and_fs();
    test_gid_kinds();
    test_root_transitions();
    test_capset_rules();
    test_unknown_kind();
    test_random_privileged();
    test_random_unprivileged();

    // drain
    req_bus.valid <= 1'b0;
    waited = 0;
    while (expected_rsp.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (5) @(negedge clk_i);
    if (expected_rsp.size() != 0) begin
      report_mismatch("responses never arrived", 64'(expected_rsp.size()), '0);
    end
    if (mismatches == 0) begin
      $display("credential_transition_unit: match");
    end else begin
      $display("credential_transition_unit: mismatch");
    end
    $finish;
  end

endmodule
